// ===== rtl/lpc_pkg.sv =====
// Shared types and constants of the status LED pattern controller.
package lpc_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET     = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_REFRESH = 2'd3
  } op_t;

  localparam logic [2:0] PAT_OFF   = 3'd0;
  localparam logic [2:0] PAT_ON    = 3'd1;
  localparam logic [2:0] PAT_SLOW  = 3'd2;
  localparam logic [2:0] PAT_FAST  = 3'd3;
  localparam logic [2:0] PAT_ERROR = 3'd4;
  localparam logic [2:0] PAT_OK    = 3'd5;

  localparam int MODE_RELAY    = 0;
  localparam int MODE_WIFI     = 1;
  localparam int MODE_SCHEDULE = 2;
  localparam int MODE_TIMER    = 3;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_MODE_MASK   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_PERIOD = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FAST_PERIOD = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_PERIOD = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_OFF   = 3'd4;

  localparam logic [3:0]  RST_MODE_MASK    = 4'd1;
  localparam logic [15:0] RST_SLOW_PERIOD  = 16'd110;
  localparam logic [15:0] RST_FAST_PERIOD  = 16'd20;
  localparam logic [15:0] RST_ERROR_PERIOD = 16'd19;
  localparam logic [7:0]  RST_ERROR_OFF    = 8'd21;

  // Lit flashes of the OK blink before it falls back to normal mode.
  localparam logic [1:0] OK_FLASHES = 2'd3;

  typedef struct packed {
    op_t        op;
    logic [2:0] pattern;
    logic       timer_active;
    logic       schedule_enabled;
    logic       relay_on;
  } item_t;

  typedef struct packed {
    logic [3:0]  mode_mask;
    logic [15:0] slow_period_ticks;
    logic [15:0] fast_period_ticks;
    logic [15:0] error_period_ticks;
    logic [7:0]  error_off_periods;
  } cfg_t;

  typedef struct packed {
    logic led_on;
    logic override_active;
    logic blinking;
    logic ok_finished;
  } result_t;

endpackage

// ===== rtl/lpc_step.sv =====
// Next-state and result logic for one word of the LED pattern controller.
module lpc_step import lpc_pkg::*; #(
  parameter int PERIOD_BITS = 16,
  parameter int COUNT_BITS  = 8
) (
  input  item_t                  item,
  input  cfg_t                   cfg,
  input  logic                   in_override,
  input  logic [2:0]             held_pattern,
  input  logic                   blink_running,
  input  logic                   led_lit,
  input  logic [PERIOD_BITS-1:0] period_left,
  input  logic [PERIOD_BITS-1:0] period_length,
  input  logic [COUNT_BITS-1:0]  periods_left,
  input  logic [COUNT_BITS-1:0]  dark_periods,
  input  logic [1:0]             ok_phase,
  output logic                   in_override_nxt,
  output logic [2:0]             held_pattern_nxt,
  output logic                   blink_running_nxt,
  output logic                   led_lit_nxt,
  output logic [PERIOD_BITS-1:0] period_left_nxt,
  output logic [PERIOD_BITS-1:0] period_length_nxt,
  output logic [COUNT_BITS-1:0]  periods_left_nxt,
  output logic [COUNT_BITS-1:0]  dark_periods_nxt,
  output logic [1:0]             ok_phase_nxt,
  output result_t                result
);

  localparam logic [32:0] PERIOD_MAX = (33'd1 << PERIOD_BITS) - 33'd1;
  localparam logic [16:0] COUNT_MAX  = (17'd1 << COUNT_BITS) - 17'd1;
  localparam logic [PERIOD_BITS-1:0] PERIOD_ONE = PERIOD_BITS'(1);
  localparam logic [COUNT_BITS-1:0]  COUNT_ONE  = COUNT_BITS'(1);

  logic                   disp_ovr;
  logic [2:0]             disp_pat;
  logic                   d_blink;
  logic                   d_lit;
  logic                   d_ok;
  logic [15:0]            d_per_raw;
  logic [7:0]             d_dark_raw;
  logic [32:0]            per_wide;
  logic [16:0]            dark_wide;
  logic [PERIOD_BITS-1:0] d_period;
  logic [COUNT_BITS-1:0]  d_dark;
  logic                   do_apply;
  logic                   done;

  // Mode and pattern the display is evaluated for.
  always_comb begin
    disp_ovr = 1'b0;
    disp_pat = held_pattern;
    unique case (item.op)
      OP_SET: begin
        disp_ovr = 1'b1;
        disp_pat = item.pattern;
      end
      OP_REFRESH: disp_ovr = in_override;
      default: disp_ovr = 1'b0;
    endcase
  end

  // Display selection: steady, dark, or a blink with its period and dark count.
  always_comb begin
    d_blink    = 1'b0;
    d_lit      = 1'b0;
    d_ok       = 1'b0;
    d_per_raw  = cfg.slow_period_ticks;
    d_dark_raw = 8'd1;
    if (disp_ovr) begin
      unique case (disp_pat)
        PAT_ON: d_lit = 1'b1;
        PAT_SLOW: d_blink = 1'b1;
        PAT_FAST: begin
          d_blink   = 1'b1;
          d_per_raw = cfg.fast_period_ticks;
        end
        PAT_ERROR: begin
          d_blink    = 1'b1;
          d_per_raw  = cfg.error_period_ticks;
          d_dark_raw = cfg.error_off_periods;
        end
        PAT_OK: begin
          d_blink   = 1'b1;
          d_ok      = 1'b1;
          d_per_raw = cfg.fast_period_ticks;
        end
        default: d_lit = 1'b0;
      endcase
    end else begin
      priority if (cfg.mode_mask[MODE_TIMER] && item.timer_active) begin
        d_blink = 1'b1;
      end else if (cfg.mode_mask[MODE_SCHEDULE] && item.schedule_enabled) begin
        d_blink = 1'b1;
      end else if (cfg.mode_mask[MODE_WIFI]) begin
        d_lit = 1'b1;
      end else if (cfg.mode_mask[MODE_RELAY]) begin
        d_lit = item.relay_on;
      end else begin
        d_blink = 1'b1;
      end
    end
  end

  // A zero period counts as one tick; values above the counter range saturate.
  assign per_wide  = 33'(d_per_raw);
  assign dark_wide = 17'(d_dark_raw);

  always_comb begin
    if (d_per_raw == 16'd0) begin
      d_period = PERIOD_ONE;
    end else if (per_wide > PERIOD_MAX) begin
      d_period = PERIOD_MAX[PERIOD_BITS-1:0];
    end else begin
      d_period = per_wide[PERIOD_BITS-1:0];
    end
    if (dark_wide > COUNT_MAX) begin
      d_dark = COUNT_MAX[COUNT_BITS-1:0];
    end else begin
      d_dark = dark_wide[COUNT_BITS-1:0];
    end
  end

  always_comb begin
    in_override_nxt   = in_override;
    held_pattern_nxt  = held_pattern;
    blink_running_nxt = blink_running;
    led_lit_nxt       = led_lit;
    period_left_nxt   = period_left;
    period_length_nxt = period_length;
    periods_left_nxt  = periods_left;
    dark_periods_nxt  = dark_periods;
    ok_phase_nxt      = ok_phase;
    do_apply          = 1'b0;
    done              = 1'b0;

    unique case (item.op)
      OP_TICK: begin
        if (blink_running) begin
          if (period_left > PERIOD_ONE) begin
            period_left_nxt = period_left - PERIOD_ONE;
          end else begin
            period_left_nxt = (period_length == '0) ? PERIOD_ONE : period_length;
            if (periods_left > COUNT_ONE) begin
              periods_left_nxt = periods_left - COUNT_ONE;
            end else if (led_lit) begin
              led_lit_nxt      = 1'b0;
              periods_left_nxt = dark_periods;
            end else begin
              led_lit_nxt      = 1'b1;
              periods_left_nxt = COUNT_ONE;
              if (ok_phase != 2'd0) begin
                ok_phase_nxt = ok_phase - 2'd1;
                if (ok_phase == 2'd1) begin
                  in_override_nxt = 1'b0;
                  do_apply        = 1'b1;
                  done            = 1'b1;
                end
              end
            end
          end
        end
      end
      OP_SET: begin
        ok_phase_nxt = 2'd0;
        if (item.pattern == PAT_OFF) begin
          in_override_nxt   = 1'b0;
          blink_running_nxt = 1'b0;
          led_lit_nxt       = 1'b0;
        end else begin
          in_override_nxt  = 1'b1;
          held_pattern_nxt = item.pattern;
          do_apply         = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (in_override) begin
          in_override_nxt = 1'b0;
          do_apply        = 1'b1;
        end
      end
      OP_REFRESH: do_apply = 1'b1;
      default: do_apply = 1'b0;
    endcase

    if (do_apply) begin
      blink_running_nxt = d_blink;
      led_lit_nxt       = d_blink | d_lit;
      if (d_blink) begin
        period_length_nxt = d_period;
        period_left_nxt   = d_period;
        dark_periods_nxt  = d_dark;
        periods_left_nxt  = COUNT_ONE;
      end
      if (d_ok) begin
        ok_phase_nxt = OK_FLASHES;
      end
    end
  end

  assign result.led_on          = led_lit_nxt;
  assign result.override_active = in_override_nxt;
  assign result.blinking        = blink_running_nxt;
  assign result.ok_finished     = done;

endmodule

// ===== rtl/led_pattern_controller.sv =====
// Top level of the status LED pattern controller with stream and register ports.
// A word accepted into the input register moves on into the result register once
// that register is free or being emptied, and its result then shows on out_tdata.
// Throughput: one word every cycle; a stalled receiver holds back the input.
// Reset (rst_n low, synchronous) empties both registers, returns the controller to
// normal mode with the LED dark and loads the configuration registers with defaults.
module led_pattern_controller import lpc_pkg::*; #(
  parameter int PERIOD_BITS = 16,
  parameter int COUNT_BITS  = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [2:0] pattern, [3] timer_active,
                                             // [4] schedule_enabled, [5] relay_on
  input  logic [1:0]             in_tuser,   // [1:0] op
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,  // [0] led_on, [1] override_active,
                                             // [2] blinking, [3] ok_finished
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg_r;
  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t step_res;
  logic    advance;

  // Controller state.
  logic                   in_override_r,   in_override_nxt;
  logic [2:0]             held_pattern_r,  held_pattern_nxt;
  logic                   blink_running_r, blink_running_nxt;
  logic                   led_lit_r,       led_lit_nxt;
  logic [PERIOD_BITS-1:0] period_left_r,   period_left_nxt;
  logic [PERIOD_BITS-1:0] period_length_r, period_length_nxt;
  logic [COUNT_BITS-1:0]  periods_left_r,  periods_left_nxt;
  logic [COUNT_BITS-1:0]  dark_periods_r,  dark_periods_nxt;
  logic [1:0]             ok_phase_r,      ok_phase_nxt;

  // The word in the input register moves on whenever the result register is
  // free or being emptied; the input side can then refill in the same cycle.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.ok_finished, out_res_r.blinking,
                       out_res_r.override_active, out_res_r.led_on};

  // Configuration registers; writes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_mask          <= RST_MODE_MASK;
      cfg_r.slow_period_ticks  <= RST_SLOW_PERIOD;
      cfg_r.fast_period_ticks  <= RST_FAST_PERIOD;
      cfg_r.error_period_ticks <= RST_ERROR_PERIOD;
      cfg_r.error_off_periods  <= RST_ERROR_OFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE_MASK:    cfg_r.mode_mask          <= cfg_data[3:0];
        CFG_SLOW_PERIOD:  cfg_r.slow_period_ticks  <= cfg_data;
        CFG_FAST_PERIOD:  cfg_r.fast_period_ticks  <= cfg_data;
        CFG_ERROR_PERIOD: cfg_r.error_period_ticks <= cfg_data;
        CFG_ERROR_OFF:    cfg_r.error_off_periods  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.op               <= op_t'(in_tuser);
      s1_item_r.pattern          <= in_tdata[2:0];
      s1_item_r.timer_active     <= in_tdata[3];
      s1_item_r.schedule_enabled <= in_tdata[4];
      s1_item_r.relay_on         <= in_tdata[5];
    end
  end

  lpc_step #(
    .PERIOD_BITS (PERIOD_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_step (
    .item              (s1_item_r),
    .cfg               (cfg_r),
    .in_override       (in_override_r),
    .held_pattern      (held_pattern_r),
    .blink_running     (blink_running_r),
    .led_lit           (led_lit_r),
    .period_left       (period_left_r),
    .period_length     (period_length_r),
    .periods_left      (periods_left_r),
    .dark_periods      (dark_periods_r),
    .ok_phase          (ok_phase_r),
    .in_override_nxt   (in_override_nxt),
    .held_pattern_nxt  (held_pattern_nxt),
    .blink_running_nxt (blink_running_nxt),
    .led_lit_nxt       (led_lit_nxt),
    .period_left_nxt   (period_left_nxt),
    .period_length_nxt (period_length_nxt),
    .periods_left_nxt  (periods_left_nxt),
    .dark_periods_nxt  (dark_periods_nxt),
    .ok_phase_nxt      (ok_phase_nxt),
    .result            (step_res)
  );

  // State commits only when the word actually moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_override_r   <= 1'b0;
      held_pattern_r  <= PAT_OFF;
      blink_running_r <= 1'b0;
      led_lit_r       <= 1'b0;
      period_left_r   <= '0;
      period_length_r <= '0;
      periods_left_r  <= '0;
      dark_periods_r  <= '0;
      ok_phase_r      <= 2'd0;
    end else if (s1_valid_r && advance) begin
      in_override_r   <= in_override_nxt;
      held_pattern_r  <= held_pattern_nxt;
      blink_running_r <= blink_running_nxt;
      led_lit_r       <= led_lit_nxt;
      period_left_r   <= period_left_nxt;
      period_length_r <= period_length_nxt;
      periods_left_r  <= periods_left_nxt;
      dark_periods_r  <= dark_periods_nxt;
      ok_phase_r      <= ok_phase_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      out_res_r <= step_res;
    end
  end

endmodule

// ===== bench/led_pattern_controller_tb.sv =====
// Self-checking testbench of the status LED pattern controller.
`timescale 1ns / 1ps

module led_pattern_controller_tb;
  import lpc_pkg::*;

  // Pattern codes beyond the named ones: the block holds override with the LED dark.
  localparam logic [2:0] PAT_SPARE_LO = 3'd6;
  localparam logic [2:0] PAT_SPARE_HI = 3'd7;

  // A cycle with no word moving on any channel counts toward the watchdog. The
  // longest quiet stretch of a correct run is the receiver hold-off below plus a
  // short gap, so the limit leaves a wide margin.
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 118;

  // One directed word: the event, its status inputs {timer, schedule, relay} and,
  // where it is obvious, the status word it must produce.
  typedef struct packed {
    op_t        op;
    logic [2:0] pattern;
    logic [2:0] tsr;
    logic       pinned;
    result_t    want;
  } row_t;

  typedef struct packed {
    logic    pinned;
    result_t value;
  } pin_t;

  localparam int ROWS     = 27;
  localparam int EDGE_ROW = 15;

  // Second half of the directed part: zero periods, zero dark periods, no mode
  // enabled, and a one-tick fast period so the OK blink finishes quickly.
  localparam cfg_t EDGE_CFG = '{mode_mask: 4'd0, slow_period_ticks: 16'd0,
                                fast_period_ticks: 16'd1, error_period_ticks: 16'd0,
                                error_off_periods: 8'd0};

  // The want column is {led_on, override_active, blinking, ok_finished}.
  row_t plan [ROWS] = '{
    // Reset configuration: only the relay indication is enabled.
    '{OP_TICK,    PAT_OFF,      3'b000, 1'b1, 4'b0000}, // tick with no blink running
    '{OP_CLEAR,   PAT_OFF,      3'b000, 1'b1, 4'b0000}, // clear in normal mode
    '{OP_REFRESH, PAT_OFF,      3'b001, 1'b1, 4'b1000}, // LED follows the relay
    '{OP_SET,     PAT_ON,       3'b000, 1'b1, 4'b1100},
    '{OP_SET,     PAT_SPARE_LO, 3'b000, 1'b1, 4'b0100},
    '{OP_SET,     PAT_SPARE_HI, 3'b111, 1'b1, 4'b0100},
    '{OP_REFRESH, PAT_OFF,      3'b000, 1'b1, 4'b0100}, // restart of a dark override
    '{OP_SET,     PAT_SLOW,     3'b000, 1'b1, 4'b1110},
    '{OP_SET,     PAT_FAST,     3'b111, 1'b1, 4'b1110},
    '{OP_SET,     PAT_ERROR,    3'b000, 1'b1, 4'b1110},
    '{OP_SET,     PAT_OK,       3'b000, 1'b1, 4'b1110},
    '{OP_CLEAR,   PAT_OFF,      3'b000, 1'b1, 4'b0000}, // leaves an OK phase behind
    '{OP_SET,     PAT_SLOW,     3'b000, 1'b1, 4'b1110}, // which a new pattern clears
    '{OP_SET,     PAT_OFF,      3'b111, 1'b1, 4'b0000}, // off: no re-evaluation
    '{OP_CLEAR,   PAT_OFF,      3'b111, 1'b1, 4'b0000},
    // Edge configuration.
    '{OP_REFRESH, PAT_OFF,      3'b000, 1'b1, 4'b1010}, // no mode: slow blink
    '{OP_TICK,    PAT_OFF,      3'b000, 1'b0, 4'b0000},
    '{OP_SET,     PAT_ERROR,    3'b000, 1'b0, 4'b0000},
    '{OP_TICK,    PAT_OFF,      3'b000, 1'b0, 4'b0000},
    '{OP_TICK,    PAT_OFF,      3'b000, 1'b0, 4'b0000},
    '{OP_SET,     PAT_OK,       3'b101, 1'b0, 4'b0000},
    '{OP_TICK,    PAT_OFF,      3'b010, 1'b0, 4'b0000},
    '{OP_TICK,    PAT_OFF,      3'b010, 1'b0, 4'b0000},
    '{OP_TICK,    PAT_OFF,      3'b010, 1'b0, 4'b0000},
    '{OP_TICK,    PAT_OFF,      3'b010, 1'b0, 4'b0000},
    '{OP_TICK,    PAT_OFF,      3'b010, 1'b0, 4'b0000},
    '{OP_TICK,    PAT_OFF,      3'b010, 1'b0, 4'b0000}  // OK blink completes here
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata   = '0;
  logic [1:0]             in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [7:0]             out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  // Status words still owed by the block, oldest first, and the typed-in
  // expectations of the directed words.
  result_t expected_status [$];
  pin_t    typed_status [$];

  int fail_count  = 0;
  int idle_cycles = 0;
  bit quiet       = 1'b0;  // no random gaps on either side while set
  bit long_hold   = 1'b0;  // asks the receiver for one long hold-off

  // Predictor state: configuration and controller state, same widths as the block.
  cfg_t regs = '{RST_MODE_MASK, RST_SLOW_PERIOD, RST_FAST_PERIOD, RST_ERROR_PERIOD,
                 RST_ERROR_OFF};
  logic        ovr_mode  = 1'b0;
  logic [2:0]  held_pat  = PAT_OFF;
  logic        blink_on  = 1'b0;
  logic        led_lit   = 1'b0;
  logic [15:0] tick_left = '0;
  logic [15:0] tick_len  = '0;
  logic [7:0]  per_left  = '0;
  logic [7:0]  per_dark  = '0;
  logic [1:0]  ok_left   = '0;

  always #5 clk = ~clk;

  led_pattern_controller i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A blink starts lit for one period; a period of zero ticks counts as one.
  function automatic void begin_blink(logic [15:0] ticks, logic [7:0] dark);
    tick_len  = (ticks == 16'd0) ? 16'd1 : ticks;
    tick_left = tick_len;
    per_dark  = dark;
    per_left  = 8'd1;
    led_lit   = 1'b1;
    blink_on  = 1'b1;
  endfunction

  // Work out what the LED shows: the held pattern in override, otherwise the
  // highest-priority enabled status that holds, or a slow blink with none.
  function automatic void show_status(logic t, logic s, logic r);
    blink_on = 1'b0;
    led_lit  = 1'b0;
    if (ovr_mode) begin
      case (held_pat)
        PAT_ON:    led_lit = 1'b1;
        PAT_SLOW:  begin_blink(regs.slow_period_ticks, 8'd1);
        PAT_FAST:  begin_blink(regs.fast_period_ticks, 8'd1);
        PAT_ERROR: begin_blink(regs.error_period_ticks, regs.error_off_periods);
        PAT_OK: begin
          ok_left = OK_FLASHES;
          begin_blink(regs.fast_period_ticks, 8'd1);
        end
        default: ;
      endcase
    end else if (regs.mode_mask[MODE_TIMER] && t) begin
      begin_blink(regs.slow_period_ticks, 8'd1);
    end else if (regs.mode_mask[MODE_SCHEDULE] && s) begin
      begin_blink(regs.slow_period_ticks, 8'd1);
    end else if (regs.mode_mask[MODE_WIFI]) begin
      led_lit = 1'b1;
    end else if (regs.mode_mask[MODE_RELAY]) begin
      led_lit = r;
    end else begin
      begin_blink(regs.slow_period_ticks, 8'd1);
    end
  endfunction

  // One blink period has run out. Zero dark periods behave as one, since the
  // dark count is only compared against one. Returns 1 when the OK blink ends.
  function automatic logic period_over(logic t, logic s, logic r);
    if (per_left > 8'd1) begin
      per_left = per_left - 8'd1;
      return 1'b0;
    end
    if (led_lit) begin
      led_lit  = 1'b0;
      per_left = per_dark;
      return 1'b0;
    end
    led_lit  = 1'b1;
    per_left = 8'd1;
    if (ok_left != 2'd0) begin
      ok_left = ok_left - 2'd1;
      if (ok_left == 2'd0) begin
        ovr_mode = 1'b0;
        show_status(t, s, r);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Advance the controller by one event and return the status word it shows.
  function automatic result_t led_step(item_t it);
    logic done;
    done = 1'b0;
    case (it.op)
      OP_TICK: begin
        if (blink_on) begin
          if (tick_left > 16'd1) begin
            tick_left = tick_left - 16'd1;
          end else begin
            tick_left = (tick_len == 16'd0) ? 16'd1 : tick_len;
            done = period_over(it.timer_active, it.schedule_enabled, it.relay_on);
          end
        end
      end
      OP_SET: begin
        ok_left = 2'd0;
        if (it.pattern == PAT_OFF) begin
          ovr_mode = 1'b0;
          blink_on = 1'b0;
          led_lit  = 1'b0;
        end else begin
          ovr_mode = 1'b1;
          held_pat = it.pattern;
          show_status(it.timer_active, it.schedule_enabled, it.relay_on);
        end
      end
      OP_CLEAR: begin
        if (ovr_mode) begin
          ovr_mode = 1'b0;
          show_status(it.timer_active, it.schedule_enabled, it.relay_on);
        end
      end
      default: show_status(it.timer_active, it.schedule_enabled, it.relay_on);
    endcase
    return {led_lit, ovr_mode, blink_on, done};
  endfunction

  function automatic void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] data);
    case (idx)
      CFG_MODE_MASK:    regs.mode_mask          = data[3:0];
      CFG_SLOW_PERIOD:  regs.slow_period_ticks  = data;
      CFG_FAST_PERIOD:  regs.fast_period_ticks  = data;
      CFG_ERROR_PERIOD: regs.error_period_ticks = data;
      CFG_ERROR_OFF:    regs.error_off_periods  = data[7:0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic want, logic got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 40)
        $display("%0t ns: %s expected %0b, got %0b", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Bus monitor and scoreboard. Everything is sampled at the rising edge, before
  // the nonblocking updates of that edge land, so no result depends on event order.
  // The input side is handled first so a same-edge result would still find its
  // expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : bus_watch
    item_t   seen;
    pin_t    pin;
    result_t want;
    if (rst_n && cfg_valid && cfg_ready)
      write_reg(cfg_index, cfg_data);
    if (rst_n && in_tvalid && in_tready) begin
      seen.op               = op_t'(in_tuser);
      seen.pattern          = in_tdata[2:0];
      seen.timer_active     = in_tdata[3];
      seen.schedule_enabled = in_tdata[4];
      seen.relay_on         = in_tdata[5];
      want = led_step(seen);
      // A directed word with a typed-in status is checked against that instead.
      if (typed_status.size() != 0) begin
        pin = typed_status.pop_front();
        if (pin.pinned)
          want = pin.value;
      end
      expected_status.push_back(want);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_status.size() == 0) begin
        fail_count++;
        if (fail_count <= 40)
          $display("%0t ns: status word %h expected none, got one", $time, out_tdata);
      end else begin
        want = expected_status.pop_front();
        check_field("led_on",          want.led_on,          out_tdata[0]);
        check_field("override_active", want.override_active, out_tdata[1]);
        check_field("blinking",        want.blinking,        out_tdata[2]);
        check_field("ok_finished",     want.ok_finished,     out_tdata[3]);
      end
    end
  end

  // Watchdog: ends a run that has stopped moving words.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
                                       : int'($urandom_range(1, 3));
  endfunction

  function automatic item_t make_item(op_t op, logic [2:0] pat, logic [2:0] tsr);
    item_t it;
    it.op               = op;
    it.pattern          = pat;
    it.timer_active     = tsr[2];
    it.schedule_enabled = tsr[1];
    it.relay_on         = tsr[0];
    return it;
  endfunction

  function automatic item_t any_item(op_t op);
    return make_item(op, 3'($urandom), 3'($urandom));
  endfunction

  // Short periods most of the time so blinks actually run through their phases.
  function automatic logic [15:0] any_period();
    return ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(0, 4));
  endfunction

  function automatic cfg_t phase_cfg(int phase);
    cfg_t c;
    case (phase)
      0: c = '{4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF};
      1: c = '{4'h0, 16'd1, 16'd1, 16'd1, 8'd1};
      2: c = '{4'($urandom), 16'd0, 16'd0, 16'd0, 8'd0};
      default: begin
        c.mode_mask          = 4'($urandom);
        c.slow_period_ticks  = any_period();
        c.fast_period_ticks  = any_period();
        c.error_period_ticks = any_period();
        c.error_off_periods  = ($urandom_range(0, 5) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0, 4));
      end
    endcase
    return c;
  endfunction

  // Offer one word, after a random gap unless the phase is quiet, and return at
  // the edge where it is taken. Valid stays high into the next word when there
  // is no gap.
  task automatic push_word(item_t it);
    int gap;
    gap = (!quiet && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, it.relay_on, it.schedule_enabled, it.timer_active, it.pattern};
    in_tuser  <= it.op;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering and wait until every status word owed has come back, then keep
  // idling so that a stray word would still show up.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all five registers back to back with an idle block. Unused upper data
  // bits carry noise, and a write to an unused index is thrown in.
  task automatic load_regs(cfg_t c);
    logic [CFG_INDEX_W-1:0] idx [6];
    logic [15:0]            val [6];
    logic [15:0]            junk;
    settle();
    junk   = 16'($urandom);
    idx[0] = CFG_MODE_MASK;    val[0] = {junk[15:4], c.mode_mask};
    idx[1] = CFG_SLOW_PERIOD;  val[1] = c.slow_period_ticks;
    idx[2] = CFG_FAST_PERIOD;  val[2] = c.fast_period_ticks;
    idx[3] = CFG_ERROR_PERIOD; val[3] = c.error_period_ticks;
    idx[4] = CFG_ERROR_OFF;    val[4] = {junk[11:4], c.error_off_periods};
    idx[5] = CFG_ERROR_OFF + CFG_INDEX_W'(1 + $urandom_range(0, 2));
    val[5] = 16'($urandom);
    for (int k = 0; k < 6; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, stretches with none, and one long hold-off while
  // the sender keeps offering, so both internal registers fill and in_tready
  // drops. Each step assigns out_tready at most once.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int len;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        len = gap_len();
        repeat (len) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int sent;
    int burst;
    int pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, first under the reset configuration, then under the edge one.
    for (int i = 0; i < ROWS; i++) begin
      if (i == EDGE_ROW)
        load_regs(EDGE_CFG);
      typed_status.push_back({plan[i].pinned, plan[i].want});
      push_word(make_item(plan[i].op, plan[i].pattern, plan[i].tsr));
    end

    // Random part. Each burst is a pattern change, a refresh, a clear or a tick
    // followed by a run of ticks, so blinks get time to run through their lit and
    // dark periods; a few words of any kind are mixed in as noise.
    for (int phase = 0; phase < PHASES; phase++) begin
      load_regs(phase_cfg(phase));
      quiet = (phase == 3 || phase == 5);
      if (phase == 3)
        long_hold = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 6)
          push_word(make_item(OP_SET,
                              ($urandom_range(0, 3) == 0) ? PAT_OK : 3'($urandom),
                              3'($urandom)));
        else if (pick < 8)
          push_word(any_item(OP_REFRESH));
        else if (pick == 8)
          push_word(any_item(OP_CLEAR));
        else
          push_word(any_item(OP_TICK));
        sent++;
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 10);
        for (int j = 0; j < burst && sent < PHASE_ITEMS; j++) begin
          if ($urandom_range(0, 15) == 0)
            push_word(any_item(op_t'($urandom_range(0, 3))));
          else
            push_word(any_item(OP_TICK));
          sent++;
        end
      end
    end

    settle();
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== led_pattern_controller.f =====
rtl/lpc_pkg.sv
rtl/lpc_step.sv
rtl/led_pattern_controller.sv
bench/led_pattern_controller_tb.sv
